// File: sv/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared constants for the double-ended queue
// Depth, index and count widths, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

    // Depth of the circular store; a power of two so that indexes wrap by
    // plain truncation.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int VAL_W    = 32;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    localparam logic [VAL_W-1:0] NONE_VALUE = '1;

    // Result beat layout in m_tdata
    localparam int OUT_W    = 106;
    localparam int OUT_BYTES_W = 112;

    typedef logic [VAL_W-1:0] value_t;

endpackage

`default_nettype wire

// File: sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
// Values live in a 64-entry synchronous RAM used as a ring; the front and
// back values are also cached in registers so each command reads at most
// one entry, the one that becomes the new end after a pop.
// ----------------------------------------------------------------------------
//
//  channel | dir | ports                     | contents
//  --------+-----+---------------------------+--------------------------------
//  command | in  | s_tvalid/s_tready         | s_tuser: command, s_tdata: value
//  result  | out | m_tvalid/m_tready         | m_tdata: popped, status, first,
//          |     |                           |   last, count, empty
//
//  Pushes, peeks and pops that leave at most one element need no RAM read.
//  A pop from a queue of three or more goes through S_FILL: the new end value
//  comes back from the RAM read port in the cycle after the read is issued.
//  The result sits in an output register; a new command is taken in the
//  same cycle that the waiting result is taken.
//  aresetn (synchronous, active low) empties the queue; the RAM is not
//  cleared, as only entries holding pushed values are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [dq_pkg::VAL_W-1:0]           s_tdata,   // [31:0] value
    input  wire  [dq_pkg::CMD_W-1:0]           s_tuser,   // [2:0] command
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // [31:0] popped_value, [33:32] status, [65:34] first_value,
    // [97:66] last_value, [104:98] element_count, [105] is_empty, rest zero
    output logic [dq_pkg::OUT_BYTES_W-1:0]     m_tdata
);
    import dq_pkg::*;

    localparam logic S_IDLE = 1'b0;   // ready for a command
    localparam logic S_FILL = 1'b1;   // waiting on RAM data for the new end

    // Element RAM
    value_t           mem [CAPACITY];
    value_t           rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic             mem_re;
    logic [IDX_W-1:0] mem_ra;

    // Queue pointers and cached ends
    logic             state_reg,   state_next;
    logic [IDX_W-1:0] front_reg,   front_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    value_t           first_reg,   first_next;
    value_t           last_reg,    last_next;
    logic             fill_front_reg, fill_front_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    value_t            o_pop_reg,   o_pop_next;
    logic [STAT_W-1:0] o_stat_reg,  o_stat_next;
    value_t            o_first_reg, o_first_next;
    value_t            o_last_reg,  o_last_next;
    logic [CNT_W-1:0]  o_cnt_reg,   o_cnt_next;

    logic             accept;
    logic             q_empty;
    logic             q_full;
    logic [IDX_W-1:0] count_idx;

    assign s_tready  = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign q_empty   = (count_reg == '0);
    assign q_full    = (count_reg == CNT_W'(CAPACITY));
    assign count_idx = count_reg[IDX_W-1:0];

    always_comb begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        fill_front_next = fill_front_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        o_pop_next      = o_pop_reg;
        o_stat_next     = o_stat_reg;
        o_first_next    = o_first_reg;
        o_last_next     = o_last_reg;
        o_cnt_next      = o_cnt_reg;
        mem_we          = 1'b0;
        mem_wa          = front_reg;
        mem_re          = 1'b0;
        mem_ra          = front_reg;

        if (accept) begin
            o_pop_next  = NONE_VALUE;
            o_stat_next = STAT_OK;
            case (s_tuser)
                CMD_PUSH_FRONT: begin
                    if (q_full) begin
                        o_stat_next = STAT_FULL;
                    end else begin
                        front_next = front_reg - IDX_W'(1);
                        mem_we     = 1'b1;
                        mem_wa     = front_reg - IDX_W'(1);
                        first_next = s_tdata;
                        if (q_empty) begin
                            last_next = s_tdata;
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_PUSH_BACK: begin
                    if (q_full) begin
                        o_stat_next = STAT_FULL;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wa    = front_reg + count_idx;
                        last_next = s_tdata;
                        if (q_empty) begin
                            first_next = s_tdata;
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT: begin
                    if (q_empty) begin
                        o_stat_next = STAT_EMPTY;
                    end else begin
                        o_pop_next = first_reg;
                        front_next = front_reg + IDX_W'(1);
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(2)) begin
                            first_next = last_reg;
                        end else if (count_reg > CNT_W'(2)) begin
                            // fetch the element behind the old front
                            mem_re          = 1'b1;
                            mem_ra          = front_reg + IDX_W'(1);
                            fill_front_next = 1'b1;
                            state_next      = S_FILL;
                        end
                    end
                end
                CMD_POP_BACK: begin
                    if (q_empty) begin
                        o_stat_next = STAT_EMPTY;
                    end else begin
                        o_pop_next = last_reg;
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(2)) begin
                            last_next = first_reg;
                        end else if (count_reg > CNT_W'(2)) begin
                            // fetch the element ahead of the old back
                            mem_re          = 1'b1;
                            mem_ra          = front_reg + count_idx - IDX_W'(2);
                            fill_front_next = 1'b0;
                            state_next      = S_FILL;
                        end
                    end
                end
                default: begin
                    // peek and unused codes
                    if (q_empty) begin
                        o_stat_next = STAT_EMPTY;
                    end
                end
            endcase
            o_cnt_next = count_next;
            if (count_next == '0) begin
                o_first_next = NONE_VALUE;
                o_last_next  = NONE_VALUE;
            end else begin
                o_first_next = first_next;
                o_last_next  = last_next;
            end
            // hold the beat back until the refilled end arrives
            m_valid_next = (state_next == S_IDLE);
        end

        if (state_reg == S_FILL) begin
            if (fill_front_reg) begin
                first_next   = rd_data_reg;
                o_first_next = rd_data_reg;
                o_last_next  = last_reg;
            end else begin
                last_next    = rd_data_reg;
                o_first_next = first_reg;
                o_last_next  = rd_data_reg;
            end
            m_valid_next = 1'b1;
            state_next   = S_IDLE;
        end
    end

    // RAM: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= s_tdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg      <= first_next;
        last_reg       <= last_next;
        fill_front_reg <= fill_front_next;
        o_pop_reg      <= o_pop_next;
        o_stat_reg     <= o_stat_next;
        o_first_reg    <= o_first_next;
        o_last_reg     <= o_last_next;
        o_cnt_reg      <= o_cnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_BYTES_W-OUT_W){1'b0}}, (o_cnt_reg == '0), o_cnt_reg,
                       o_last_reg, o_first_reg, o_stat_reg, o_pop_reg};

endmodule

`default_nettype wire

// File: sv/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker: port-level checks for the double-ended queue
// Watches the result channel and checks beat contents for consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [dq_pkg::OUT_BYTES_W-1:0]  m_tdata
);
    import dq_pkg::*;

    logic [CNT_W-1:0]  cnt;
    logic [STAT_W-1:0] stat;
    assign cnt  = m_tdata[104:98];
    assign stat = m_tdata[33:32];

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> cnt <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_empty_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[105] |->
            m_tdata[65:34] == NONE_VALUE && m_tdata[97:66] == NONE_VALUE
            && m_tdata[31:0] == NONE_VALUE || m_tvalid && m_tdata[105] && stat == STAT_OK)
        else $error("empty queue reports end values");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && stat == STAT_FULL |-> cnt == CNT_W'(CAPACITY))
        else $error("push dropped while not full");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[105] == (cnt == '0))
        else $error("empty flag disagrees with count");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
